// File: rtl/ctw_pkg.sv
// Shared types, codes and constants for the text console writer.
`timescale 1ns / 1ps

package ctw_pkg;

  localparam int NUM_COLUMNS_DEF = 80;
  localparam int NUM_ROWS_DEF    = 25;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ATTR   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_CYCLE = 1'd1;

  localparam logic [7:0] ATTR_RESET   = 8'h09;
  localparam logic [7:0] COLOR_STEP   = 8'd5;
  localparam logic [7:0] ATTR_MASK    = 8'h0F;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] RETURN_CODE  = 8'd13;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FILL_SPACE,
    FILL_CLEAR,
    FILL_RESET
  } fill_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_NEWLINE,
    ST_SCROLL,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  ld_item;
    logic  calc_addr;
    logic  wr_char;
    logic  line_feed;
    logic  fill_all_start;
    logic  fill_wr;
    fill_t fill_sel;
    logic  home;
    logic  rd_cell;
    logic  ld_out;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  is_newline;
    logic  col_last;
    logic  line_last;
    logic  fill_row_last;
    logic  fill_all_last;
    logic  out_busy;
  } sts_t;

endpackage

// File: rtl/ctw_datapath.sv
// Console datapath: cursor, scroll row, attribute, screen store and output register.
`timescale 1ns / 1ps

module ctw_datapath #(
  parameter int NUM_COLUMNS = ctw_pkg::NUM_COLUMNS_DEF,
  parameter int NUM_ROWS    = ctw_pkg::NUM_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ctw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ctw_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [ctw_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic [ctw_pkg::IN_TUSER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ctw_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  ctw_pkg::cmd_t                       cmd,
  output ctw_pkg::sts_t                       sts
);

  localparam int CELLS = NUM_COLUMNS * NUM_ROWS;
  localparam int CW    = $clog2(NUM_COLUMNS);
  localparam int RW    = $clog2(NUM_ROWS);
  localparam int AW    = $clog2(CELLS);

  ctw_pkg::kind_t kind_q;
  logic [7:0]     code_q;
  logic [6:0]     rcol_q;
  logic [4:0]     rrow_q;

  logic [CW-1:0]  col;
  logic [RW-1:0]  line;
  logic [RW-1:0]  top;
  logic [7:0]     cur_attr;
  logic           color_en;

  logic [AW-1:0]  addr;
  logic           in_range;
  logic [AW-1:0]  fill_addr;
  logic [CW-1:0]  fill_col;
  logic           scrolled;

  logic [15:0]    mem [CELLS];
  logic [15:0]    rd_q;

  logic [RW-1:0]  row_sel;
  logic [CW-1:0]  col_sel;
  logic [RW:0]    ring_sum;
  logic [RW-1:0]  ring;
  logic [AW-1:0]  addr_calc;
  logic           in_range_calc;
  logic [AW-1:0]  fill_base;
  logic           col_last;
  logic           line_last;
  logic           top_last;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [15:0]    mem_wdata;
  logic [7:0]     fill_char;
  logic [7:0]     fill_attr;

  logic [15:0]    cell_word;
  logic [AW-1:0]  pos;

  assign col_last  = (col == CW'(NUM_COLUMNS - 1));
  assign line_last = (line == RW'(NUM_ROWS - 1));
  assign top_last  = (top == RW'(NUM_ROWS - 1));

  always_comb begin
    if (kind_q == ctw_pkg::KIND_READ) begin
      row_sel = RW'(rrow_q);
      col_sel = CW'(rcol_q);
    end else begin
      row_sel = line;
      col_sel = col;
    end
    ring_sum = {1'b0, row_sel} + {1'b0, top};
    if (ring_sum >= (RW+1)'(NUM_ROWS)) begin
      ring = RW'(ring_sum - (RW+1)'(NUM_ROWS));
    end else begin
      ring = RW'(ring_sum);
    end
    addr_calc     = AW'(ring) * AW'(NUM_COLUMNS) + AW'(col_sel);
    in_range_calc = (32'(rcol_q) < 32'(NUM_COLUMNS)) && (32'(rrow_q) < 32'(NUM_ROWS));
    fill_base     = AW'(top) * AW'(NUM_COLUMNS);
  end

  always_comb begin
    case (cmd.fill_sel)
      ctw_pkg::FILL_SPACE: begin
        fill_char = ctw_pkg::SPACE_CODE;
        fill_attr = cur_attr;
      end
      ctw_pkg::FILL_CLEAR: begin
        fill_char = 8'h00;
        fill_attr = cur_attr;
      end
      default: begin
        fill_char = 8'h00;
        fill_attr = 8'h00;
      end
    endcase
    mem_we    = cmd.wr_char || cmd.fill_wr;
    mem_waddr = cmd.fill_wr ? fill_addr : addr;
    mem_wdata = cmd.fill_wr ? {fill_attr, fill_char} : {cur_attr, code_q};
  end

  always_comb begin
    cell_word = ((kind_q == ctw_pkg::KIND_READ) && in_range) ? rd_q : 16'h0000;
    pos       = AW'(line) * AW'(NUM_COLUMNS) + AW'(col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      line      <= '0;
      top       <= '0;
      cur_attr  <= ctw_pkg::ATTR_RESET;
      color_en  <= 1'b0;
      fill_addr <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ctw_pkg::REG_TEXT_ATTR:   cur_attr <= cfg_data;
          ctw_pkg::REG_COLOR_CYCLE: color_en <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.wr_char && !col_last) begin
        col <= col + 1'b1;
      end
      if (cmd.line_feed) begin
        col <= '0;
        if (line_last) begin
          top       <= top_last ? '0 : top + 1'b1;
          fill_addr <= fill_base;
        end else begin
          line <= line + 1'b1;
        end
      end
      if (cmd.fill_all_start) begin
        fill_addr <= '0;
      end
      if (cmd.fill_wr) begin
        fill_addr <= fill_addr + 1'b1;
      end
      if (cmd.home) begin
        col  <= '0;
        line <= '0;
      end
      if (cmd.ld_out) begin
        m_tvalid <= 1'b1;
        if (kind_q == ctw_pkg::KIND_CHAR && color_en) begin
          cur_attr <= (cur_attr + ctw_pkg::COLOR_STEP) & ctw_pkg::ATTR_MASK;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      kind_q   <= ctw_pkg::kind_t'(s_tuser[1:0]);
      code_q   <= s_tdata[7:0];
      rcol_q   <= s_tdata[14:8];
      rrow_q   <= s_tdata[19:15];
      scrolled <= 1'b0;
    end
    if (cmd.calc_addr) begin
      addr     <= addr_calc;
      in_range <= in_range_calc;
    end
    if (cmd.line_feed && line_last) begin
      fill_col <= '0;
      scrolled <= 1'b1;
    end else if (cmd.fill_wr) begin
      fill_col <= fill_col + 1'b1;
    end
    if (cmd.ld_out) begin
      m_tdata <= {3'b000, scrolled, 5'(top), 11'(pos), 5'(line), 7'(col),
                  cell_word[15:8], cell_word[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_cell) begin
      rd_q <= mem[addr];
    end
  end

  assign sts.kind          = kind_q;
  assign sts.is_newline    = (code_q == ctw_pkg::NEWLINE_CODE) ||
                             (code_q == ctw_pkg::RETURN_CODE);
  assign sts.col_last      = col_last;
  assign sts.line_last     = line_last;
  assign sts.fill_row_last = (fill_col == CW'(NUM_COLUMNS - 1));
  assign sts.fill_all_last = (fill_addr == AW'(CELLS - 1));
  assign sts.out_busy      = m_tvalid && !m_tready;

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(col) < 32'(NUM_COLUMNS)) && (32'(line) < 32'(NUM_ROWS)) &&
    (32'(top) < 32'(NUM_ROWS)))
    else $error("cursor or scroll row out of range");

  a_top_moves_on_feed: assert property (@(posedge clk) disable iff (rst)
    (top != $past(top)) |-> ($past(cmd.line_feed) && $past(line_last)))
    else $error("scroll row changed without a scroll");

endmodule

// File: rtl/ctw_ctrl.sv
// Console controller: sequences decode, cell write, newline, scroll, clear and read.
`timescale 1ns / 1ps

module ctw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output ctw_pkg::cmd_t cmd,
  input  ctw_pkg::sts_t sts
);

  ctw_pkg::state_t state;
  ctw_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ctw_pkg::ST_INIT: begin
        if (sts.fill_all_last) state_next = ctw_pkg::ST_IDLE;
      end
      ctw_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = ctw_pkg::ST_DECODE;
      end
      ctw_pkg::ST_DECODE: begin
        unique case (sts.kind)
          ctw_pkg::KIND_CHAR:
            state_next = sts.is_newline ? ctw_pkg::ST_NEWLINE : ctw_pkg::ST_WRITE;
          ctw_pkg::KIND_CLEAR: state_next = ctw_pkg::ST_CLEAR;
          ctw_pkg::KIND_READ:  state_next = ctw_pkg::ST_READ;
          default:             state_next = ctw_pkg::ST_DONE;
        endcase
      end
      ctw_pkg::ST_WRITE: begin
        state_next = sts.col_last ? ctw_pkg::ST_NEWLINE : ctw_pkg::ST_DONE;
      end
      ctw_pkg::ST_NEWLINE: begin
        state_next = sts.line_last ? ctw_pkg::ST_SCROLL : ctw_pkg::ST_DONE;
      end
      ctw_pkg::ST_SCROLL: begin
        if (sts.fill_row_last) state_next = ctw_pkg::ST_DONE;
      end
      ctw_pkg::ST_CLEAR: begin
        if (sts.fill_all_last) state_next = ctw_pkg::ST_DONE;
      end
      ctw_pkg::ST_READ: begin
        state_next = ctw_pkg::ST_DONE;
      end
      ctw_pkg::ST_DONE: begin
        if (!sts.out_busy) state_next = ctw_pkg::ST_IDLE;
      end
      default: state_next = ctw_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    cmd.fill_sel = ctw_pkg::FILL_RESET;
    unique case (state)
      ctw_pkg::ST_INIT: begin
        cmd.fill_wr  = 1'b1;
        cmd.fill_sel = ctw_pkg::FILL_RESET;
      end
      ctw_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.ld_item = s_tvalid;
      end
      ctw_pkg::ST_DECODE: begin
        cmd.calc_addr      = 1'b1;
        cmd.fill_all_start = (sts.kind == ctw_pkg::KIND_CLEAR);
      end
      ctw_pkg::ST_WRITE: begin
        cmd.wr_char = 1'b1;
      end
      ctw_pkg::ST_NEWLINE: begin
        cmd.line_feed = 1'b1;
      end
      ctw_pkg::ST_SCROLL: begin
        cmd.fill_wr  = 1'b1;
        cmd.fill_sel = ctw_pkg::FILL_SPACE;
      end
      ctw_pkg::ST_CLEAR: begin
        cmd.fill_wr  = 1'b1;
        cmd.fill_sel = ctw_pkg::FILL_CLEAR;
        cmd.home     = sts.fill_all_last;
      end
      ctw_pkg::ST_READ: begin
        cmd.rd_cell = 1'b1;
      end
      ctw_pkg::ST_DONE: begin
        cmd.ld_out = !sts.out_busy;
      end
      default: ;
    endcase
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_item |=> (state == ctw_pkg::ST_DECODE))
    else $error("accepted word not decoded next");

  a_scroll_walks_row: assert property (@(posedge clk) disable iff (rst)
    (state == ctw_pkg::ST_SCROLL && !sts.fill_row_last) |=> (state == ctw_pkg::ST_SCROLL))
    else $error("scroll fill stopped early");

  a_bottom_scrolls: assert property (@(posedge clk) disable iff (rst)
    (state == ctw_pkg::ST_NEWLINE && sts.line_last) |=> (state == ctw_pkg::ST_SCROLL))
    else $error("newline on last row did not scroll");

endmodule

// File: rtl/text_console_writer_top.sv
// Top level of the text console writer.
`timescale 1ns / 1ps

// Character-cell console with a ring screen store of NUM_COLUMNS x NUM_ROWS cells.
// Input stream: one word per item; s_tuser carries the kind (character, clear,
// read cell), s_tdata the character code and the read column and row.
// Output stream: exactly one word per input word with the read cell, the cursor,
// the linear cursor position, the scroll row and a scrolled flag.
// Configuration: cfg_we/cfg_index/cfg_data load the text attribute (index 0) or
// the color cycle enable (index 1); write only while no word is in flight.
// Sequence: a character is decoded, written to its cell and loaded as output word;
// a newline or read does a line feed or cell read in place of the write. A scroll
// adds a row fill, one cell a cycle; a character at the last column adds its newline,
// plus the row fill when it scrolls. A clear rewrites all NUM_COLUMNS*NUM_ROWS cells.
// One item is worked at a time; the next is accepted once the last result is loaded.
// Reset: after rst the store is swept to zero, one cell a cycle, over all
// NUM_COLUMNS*NUM_ROWS cells (2000 at defaults); s_tready stays low meanwhile.
// Stall: the output word is held in a register; the next item is accepted while
// it waits, and its result waits until m_tready takes the held word.

module text_console_writer_top #(
  parameter int NUM_COLUMNS = ctw_pkg::NUM_COLUMNS_DEF,
  parameter int NUM_ROWS    = ctw_pkg::NUM_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ctw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ctw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // char_code[7:0], read_col[14:8], read_row[19:15], zero[23:20]
  input  logic [ctw_pkg::IN_TDATA_W-1:0]  s_tdata,
  // kind[1:0]
  input  logic [ctw_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // cell_char[7:0], cell_attr[15:8], cursor_col[22:16], cursor_row[27:23],
  // cursor_pos[38:28], scroll_row[43:39], scrolled[44], zero[47:45]
  output logic [ctw_pkg::OUT_TDATA_W-1:0] m_tdata
);

  ctw_pkg::cmd_t cmd;
  ctw_pkg::sts_t sts;

  ctw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ctw_datapath #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
